>>> sv/bprl_pkg.sv
// Package for the media key repeat and long-press core.
// Holds action and key codes, register indexes, reset values and shared types.
// No dependencies.
`default_nettype none

package bprl_pkg;

  localparam logic [1:0] ACT_DOWN  = 2'd0;
  localparam logic [1:0] ACT_UP    = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic [2:0] KEY_PWR   = 3'd0;
  localparam logic [2:0] KEY_PLAY  = 3'd1;
  localparam logic [2:0] KEY_NEXT  = 3'd2;
  localparam logic [2:0] KEY_PREV  = 3'd3;
  localparam logic [2:0] KEY_VOLUP = 3'd4;
  localparam logic [2:0] KEY_VOLDN = 3'd5;

  localparam logic [2:0] REG_VOLUME_STEP   = 3'd0;
  localparam logic [2:0] REG_REPEAT_DELAY  = 3'd1;
  localparam logic [2:0] REG_REPEAT_IVAL   = 3'd2;
  localparam logic [2:0] REG_POWER_HOLD    = 3'd3;
  localparam logic [2:0] REG_SEEK_HOLD     = 3'd4;
  localparam logic [2:0] REG_SEEK_IVAL     = 3'd5;

  localparam logic [6:0]  RST_VOLUME_STEP  = 7'd1;
  localparam logic [15:0] RST_REPEAT_DELAY = 16'd350;
  localparam logic [15:0] RST_REPEAT_IVAL  = 16'd60;
  localparam logic [15:0] RST_POWER_HOLD   = 16'd700;
  localparam logic [15:0] RST_SEEK_HOLD    = 16'd400;
  localparam logic [15:0] RST_SEEK_IVAL    = 16'd100;

  // pending flag bits
  localparam int F_PWR_TAP    = 0;
  localparam int F_PWR_LONG   = 1;
  localparam int F_NXT_TAP    = 2;
  localparam int F_PRV_TAP    = 3;
  localparam int F_SEEK_FIRST = 4;

  typedef struct packed {
    logic [6:0]  volume_step;
    logic [15:0] repeat_initial_delay;
    logic [15:0] repeat_interval;
    logic [15:0] power_hold_time;
    logic [15:0] seek_hold_time;
    logic [15:0] seek_interval;
  } cfg_t;

  typedef struct packed {
    logic               power_tap;
    logic               power_long;
    logic [7:0]         play_count;
    logic               next_tap;
    logic               prev_tap;
    logic signed [15:0] volume_change;
    logic [15:0]        seek_steps;
    logic               seek_first;
  } result_t;

  function automatic logic signed [15:0] vol_add(input logic signed [15:0] acc,
                                                 input logic [6:0] st,
                                                 input logic neg);
    logic signed [16:0] d;
    logic signed [16:0] s;
    d = neg ? -$signed({10'b0, st}) : $signed({10'b0, st});
    s = $signed({acc[15], acc}) + d;
    if (s > 17'sd32767) begin
      return 16'sh7fff;
    end else if (s < -17'sd32768) begin
      return 16'sh8000;
    end else begin
      return s[15:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/bprl_engine.sv
// Key state engine: held/fired/due state, millisecond clock, flags and counters.
// Applies one item per step and presents the result for it.
// Depends on bprl_pkg.
`default_nettype none

module bprl_engine #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic [1:0]         action,
  input  wire logic [2:0]         key,
  input  wire bprl_pkg::cfg_t     cfg,
  output bprl_pkg::result_t       result
);

  logic [TIME_WIDTH-1:0] clock_ms, clock_ms_next;
  logic                  up_held, up_held_next, down_held, down_held_next;
  logic [TIME_WIDTH-1:0] up_due, up_due_next, down_due, down_due_next;
  logic                  pwr_held, pwr_held_next, pwr_fired, pwr_fired_next;
  logic [TIME_WIDTH-1:0] pwr_due, pwr_due_next;
  logic                  nxt_held, nxt_held_next, nxt_fired, nxt_fired_next;
  logic [TIME_WIDTH-1:0] nxt_due, nxt_due_next;
  logic [4:0]            pending_flags, pending_flags_next;
  logic [7:0]            play_counter, play_counter_next;
  logic signed [15:0]    volume_acc, volume_acc_next;
  logic [15:0]           seek_acc, seek_acc_next;

  logic [TIME_WIDTH-1:0] now_inc;
  logic [TIME_WIDTH-1:0] d_up, d_dn, d_pwr, d_nxt;

  assign now_inc = clock_ms + TIME_WIDTH'(1);
  // deadline differences against the advanced clock; due when top bit clear
  assign d_up  = now_inc - up_due;
  assign d_dn  = now_inc - down_due;
  assign d_pwr = now_inc - pwr_due;
  assign d_nxt = now_inc - nxt_due;

  always_comb begin
    clock_ms_next      = clock_ms;
    up_held_next       = up_held;
    down_held_next     = down_held;
    up_due_next        = up_due;
    down_due_next      = down_due;
    pwr_held_next      = pwr_held;
    pwr_fired_next     = pwr_fired;
    pwr_due_next       = pwr_due;
    nxt_held_next      = nxt_held;
    nxt_fired_next     = nxt_fired;
    nxt_due_next       = nxt_due;
    pending_flags_next = pending_flags;
    play_counter_next  = play_counter;
    volume_acc_next    = volume_acc;
    seek_acc_next      = seek_acc;
    case (action)
      bprl_pkg::ACT_DOWN: begin
        case (key)
          bprl_pkg::KEY_PWR: begin
            pwr_held_next  = 1'b1;
            pwr_fired_next = 1'b0;
            pwr_due_next   = clock_ms + TIME_WIDTH'(cfg.power_hold_time);
          end
          bprl_pkg::KEY_PLAY: begin
            if (play_counter != 8'hff) play_counter_next = play_counter + 8'd1;
          end
          bprl_pkg::KEY_NEXT: begin
            nxt_held_next  = 1'b1;
            nxt_fired_next = 1'b0;
            nxt_due_next   = clock_ms + TIME_WIDTH'(cfg.seek_hold_time);
          end
          bprl_pkg::KEY_PREV: begin
            pending_flags_next[bprl_pkg::F_PRV_TAP] = 1'b1;
          end
          bprl_pkg::KEY_VOLUP: begin
            volume_acc_next = bprl_pkg::vol_add(volume_acc, cfg.volume_step, 1'b0);
            up_held_next    = 1'b1;
            up_due_next     = clock_ms + TIME_WIDTH'(cfg.repeat_initial_delay);
          end
          bprl_pkg::KEY_VOLDN: begin
            volume_acc_next = bprl_pkg::vol_add(volume_acc, cfg.volume_step, 1'b1);
            down_held_next  = 1'b1;
            down_due_next   = clock_ms + TIME_WIDTH'(cfg.repeat_initial_delay);
          end
          default: ;
        endcase
      end
      bprl_pkg::ACT_UP: begin
        case (key)
          bprl_pkg::KEY_PWR: begin
            if (pwr_held && !pwr_fired) pending_flags_next[bprl_pkg::F_PWR_TAP] = 1'b1;
            pwr_held_next = 1'b0;
          end
          bprl_pkg::KEY_NEXT: begin
            if (nxt_held && !nxt_fired) pending_flags_next[bprl_pkg::F_NXT_TAP] = 1'b1;
            nxt_held_next = 1'b0;
          end
          bprl_pkg::KEY_VOLUP: up_held_next = 1'b0;
          bprl_pkg::KEY_VOLDN: down_held_next = 1'b0;
          default: ;
        endcase
      end
      bprl_pkg::ACT_TICK: begin
        clock_ms_next = now_inc;
        if (up_held && !d_up[TIME_WIDTH-1]) begin
          volume_acc_next = bprl_pkg::vol_add(volume_acc, cfg.volume_step, 1'b0);
          up_due_next     = now_inc + TIME_WIDTH'(cfg.repeat_interval);
        end
        if (down_held && !d_dn[TIME_WIDTH-1]) begin
          volume_acc_next = bprl_pkg::vol_add(volume_acc_next, cfg.volume_step, 1'b1);
          down_due_next   = now_inc + TIME_WIDTH'(cfg.repeat_interval);
        end
        if (pwr_held && !pwr_fired && !d_pwr[TIME_WIDTH-1]) begin
          pwr_fired_next = 1'b1;
          pending_flags_next[bprl_pkg::F_PWR_LONG] = 1'b1;
        end
        if (nxt_held && !d_nxt[TIME_WIDTH-1]) begin
          if (seek_acc != 16'hffff) seek_acc_next = seek_acc + 16'd1;
          if (!nxt_fired) begin
            nxt_fired_next = 1'b1;
            pending_flags_next[bprl_pkg::F_SEEK_FIRST] = 1'b1;
          end
          nxt_due_next = now_inc + TIME_WIDTH'(cfg.seek_interval);
        end
      end
      bprl_pkg::ACT_CLEAR: begin
        pending_flags_next = '0;
        play_counter_next  = '0;
        volume_acc_next    = '0;
        seek_acc_next      = '0;
      end
      default: ;
    endcase
  end

  // read-and-clear reports the state before clearing
  always_comb begin
    if (action == bprl_pkg::ACT_CLEAR) begin
      result.power_tap     = pending_flags[bprl_pkg::F_PWR_TAP];
      result.power_long    = pending_flags[bprl_pkg::F_PWR_LONG];
      result.play_count    = play_counter;
      result.next_tap      = pending_flags[bprl_pkg::F_NXT_TAP];
      result.prev_tap      = pending_flags[bprl_pkg::F_PRV_TAP];
      result.volume_change = volume_acc;
      result.seek_steps    = seek_acc;
      result.seek_first    = pending_flags[bprl_pkg::F_SEEK_FIRST];
    end else begin
      result.power_tap     = pending_flags_next[bprl_pkg::F_PWR_TAP];
      result.power_long    = pending_flags_next[bprl_pkg::F_PWR_LONG];
      result.play_count    = play_counter_next;
      result.next_tap      = pending_flags_next[bprl_pkg::F_NXT_TAP];
      result.prev_tap      = pending_flags_next[bprl_pkg::F_PRV_TAP];
      result.volume_change = volume_acc_next;
      result.seek_steps    = seek_acc_next;
      result.seek_first    = pending_flags_next[bprl_pkg::F_SEEK_FIRST];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ms      <= '0;
      up_held       <= 1'b0;
      down_held     <= 1'b0;
      up_due        <= '0;
      down_due      <= '0;
      pwr_held      <= 1'b0;
      pwr_fired     <= 1'b0;
      pwr_due       <= '0;
      nxt_held      <= 1'b0;
      nxt_fired     <= 1'b0;
      nxt_due       <= '0;
      pending_flags <= '0;
      play_counter  <= '0;
      volume_acc    <= '0;
      seek_acc      <= '0;
    end else if (step) begin
      clock_ms      <= clock_ms_next;
      up_held       <= up_held_next;
      down_held     <= down_held_next;
      up_due        <= up_due_next;
      down_due      <= down_due_next;
      pwr_held      <= pwr_held_next;
      pwr_fired     <= pwr_fired_next;
      pwr_due       <= pwr_due_next;
      nxt_held      <= nxt_held_next;
      nxt_fired     <= nxt_fired_next;
      nxt_due       <= nxt_due_next;
      pending_flags <= pending_flags_next;
      play_counter  <= play_counter_next;
      volume_acc    <= volume_acc_next;
      seek_acc      <= seek_acc_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/button_press_repeat_longpress_core.sv
// Top level of the media key auto-repeat and long-press core.
// Holds the input register, configuration registers and result register.
// Depends on bprl_pkg and bprl_engine.
//
// One item per clock sustained while results are taken. An accepted item sits in
// the input register, is applied to the key state and lands in the result
// register, from which its result is offered. The result register lets
// the input side keep taking items while a result waits; input stalls only
// when both the input and result registers are full and the result is held
// off. Times are counted in tick items on a TIME_WIDTH-bit wrapping clock;
// configuration writes are always taken (cfg_ready is tied high) and belong
// only to idle periods.
`default_nettype none

module button_press_repeat_longpress_core #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         action,
  input  wire logic [2:0]         key,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    power_tap,
  output logic                    power_long,
  output logic [7:0]              play_count,
  output logic                    next_tap,
  output logic                    prev_tap,
  output logic signed [15:0]      volume_change,
  output logic [15:0]             seek_steps,
  output logic                    seek_first,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  logic              s1_valid;
  logic [1:0]        s1_action;
  logic [2:0]        s1_key;
  logic              move;
  logic              accept;
  bprl_pkg::cfg_t    cfg;
  bprl_pkg::result_t res_next;
  bprl_pkg::result_t res;

  assign move     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= accept || (s1_valid && !move);
      out_valid <= move || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= action;
      s1_key    <= key;
    end
    if (move) res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volume_step          <= bprl_pkg::RST_VOLUME_STEP;
      cfg.repeat_initial_delay <= bprl_pkg::RST_REPEAT_DELAY;
      cfg.repeat_interval      <= bprl_pkg::RST_REPEAT_IVAL;
      cfg.power_hold_time      <= bprl_pkg::RST_POWER_HOLD;
      cfg.seek_hold_time       <= bprl_pkg::RST_SEEK_HOLD;
      cfg.seek_interval        <= bprl_pkg::RST_SEEK_IVAL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bprl_pkg::REG_VOLUME_STEP:  cfg.volume_step          <= cfg_data[6:0];
        bprl_pkg::REG_REPEAT_DELAY: cfg.repeat_initial_delay <= cfg_data;
        bprl_pkg::REG_REPEAT_IVAL:  cfg.repeat_interval      <= cfg_data;
        bprl_pkg::REG_POWER_HOLD:   cfg.power_hold_time      <= cfg_data;
        bprl_pkg::REG_SEEK_HOLD:    cfg.seek_hold_time       <= cfg_data;
        bprl_pkg::REG_SEEK_IVAL:    cfg.seek_interval        <= cfg_data;
        default: ;
      endcase
    end
  end

  bprl_engine #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (move),
    .action (s1_action),
    .key    (s1_key),
    .cfg    (cfg),
    .result (res_next)
  );

  assign power_tap     = res.power_tap;
  assign power_long    = res.power_long;
  assign play_count    = res.play_count;
  assign next_tap      = res.next_tap;
  assign prev_tap      = res.prev_tap;
  assign volume_change = res.volume_change;
  assign seek_steps    = res.seek_steps;
  assign seek_first    = res.seek_first;

endmodule

`default_nettype wire

>>> bench/media_key_checker.sv
// Checker for button_press_repeat_longpress_core: watches the config, item and result
// channels, keeps its own model of the key timers and compares every result.
// Depends on bprl_pkg.
`timescale 1ns / 1ps

module media_key_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         action,
  input  logic [2:0]         key,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               power_tap,
  input  logic               power_long,
  input  logic [7:0]         play_count,
  input  logic               next_tap,
  input  logic               prev_tap,
  input  logic signed [15:0] volume_change,
  input  logic [15:0]        seek_steps,
  input  logic               seek_first,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 errors,
  output int                 outstanding
);

  bprl_pkg::cfg_t     cfg;
  logic [31:0]        now_ms;
  logic               up_held, dn_held, pwr_held, pwr_fired, nxt_held, nxt_fired;
  logic [31:0]        up_due, dn_due, pwr_due, nxt_due;
  logic [4:0]         flags;
  logic [7:0]         plays;
  logic signed [15:0] vol;
  logic [15:0]        seeks;

  bprl_pkg::result_t expected_reports[$];

  function automatic void reset_keys();
    cfg.volume_step          = bprl_pkg::RST_VOLUME_STEP;
    cfg.repeat_initial_delay = bprl_pkg::RST_REPEAT_DELAY;
    cfg.repeat_interval      = bprl_pkg::RST_REPEAT_IVAL;
    cfg.power_hold_time      = bprl_pkg::RST_POWER_HOLD;
    cfg.seek_hold_time       = bprl_pkg::RST_SEEK_HOLD;
    cfg.seek_interval        = bprl_pkg::RST_SEEK_IVAL;
    now_ms = '0;
    {up_held, dn_held, pwr_held, pwr_fired, nxt_held, nxt_fired} = '0;
    {up_due, dn_due, pwr_due, nxt_due} = '0;
    flags = '0;
    plays = '0;
    vol = '0;
    seeks = '0;
  endfunction

  function automatic logic signed [15:0] clamp_vol(input logic signed [15:0] acc,
                                                   input int delta);
    int s;
    s = int'(acc) + delta;
    if (s > 32767) return 16'sh7fff;
    if (s < -32768) return 16'sh8000;
    return 16'(s);
  endfunction

  // due once (now - due) has its top bit clear
  function automatic logic reached(input logic [31:0] due);
    logic [31:0] d;
    d = now_ms - due;
    return !d[31];
  endfunction

  function automatic void key_pressed(input logic [2:0] k);
    case (k)
      bprl_pkg::KEY_PWR: begin
        pwr_held = 1'b1;
        pwr_fired = 1'b0;
        pwr_due = now_ms + 32'(cfg.power_hold_time);
      end
      bprl_pkg::KEY_PLAY: begin
        if (plays != 8'hff) plays++;
      end
      bprl_pkg::KEY_NEXT: begin
        nxt_held = 1'b1;
        nxt_fired = 1'b0;
        nxt_due = now_ms + 32'(cfg.seek_hold_time);
      end
      bprl_pkg::KEY_PREV: flags[bprl_pkg::F_PRV_TAP] = 1'b1;
      bprl_pkg::KEY_VOLUP: begin
        vol = clamp_vol(vol, int'(cfg.volume_step));
        up_held = 1'b1;
        up_due = now_ms + 32'(cfg.repeat_initial_delay);
      end
      bprl_pkg::KEY_VOLDN: begin
        vol = clamp_vol(vol, -int'(cfg.volume_step));
        dn_held = 1'b1;
        dn_due = now_ms + 32'(cfg.repeat_initial_delay);
      end
      default: ;
    endcase
  endfunction

  function automatic void key_released(input logic [2:0] k);
    case (k)
      bprl_pkg::KEY_PWR: begin
        if (pwr_held && !pwr_fired) flags[bprl_pkg::F_PWR_TAP] = 1'b1;
        pwr_held = 1'b0;
      end
      bprl_pkg::KEY_NEXT: begin
        if (nxt_held && !nxt_fired) flags[bprl_pkg::F_NXT_TAP] = 1'b1;
        nxt_held = 1'b0;
      end
      bprl_pkg::KEY_VOLUP: up_held = 1'b0;
      bprl_pkg::KEY_VOLDN: dn_held = 1'b0;
      default: ;
    endcase
  endfunction

  function automatic void ms_tick();
    now_ms = now_ms + 32'd1;
    if (up_held && reached(up_due)) begin
      vol = clamp_vol(vol, int'(cfg.volume_step));
      up_due = now_ms + 32'(cfg.repeat_interval);
    end
    if (dn_held && reached(dn_due)) begin
      vol = clamp_vol(vol, -int'(cfg.volume_step));
      dn_due = now_ms + 32'(cfg.repeat_interval);
    end
    if (pwr_held && !pwr_fired && reached(pwr_due)) begin
      pwr_fired = 1'b1;
      flags[bprl_pkg::F_PWR_LONG] = 1'b1;
    end
    if (nxt_held && reached(nxt_due)) begin
      if (seeks != 16'hffff) seeks++;
      if (!nxt_fired) begin
        nxt_fired = 1'b1;
        flags[bprl_pkg::F_SEEK_FIRST] = 1'b1;
      end
      nxt_due = now_ms + 32'(cfg.seek_interval);
    end
  endfunction

  function automatic bprl_pkg::result_t predict_key_item(input logic [1:0] act,
                                                         input logic [2:0] k);
    bprl_pkg::result_t r;
    case (act)
      bprl_pkg::ACT_DOWN: key_pressed(k);
      bprl_pkg::ACT_UP:   key_released(k);
      bprl_pkg::ACT_TICK: ms_tick();
      default: ;
    endcase
    r.power_tap     = flags[bprl_pkg::F_PWR_TAP];
    r.power_long    = flags[bprl_pkg::F_PWR_LONG];
    r.play_count    = plays;
    r.next_tap      = flags[bprl_pkg::F_NXT_TAP];
    r.prev_tap      = flags[bprl_pkg::F_PRV_TAP];
    r.volume_change = vol;
    r.seek_steps    = seeks;
    r.seek_first    = flags[bprl_pkg::F_SEEK_FIRST];
    if (act == bprl_pkg::ACT_CLEAR) begin
      flags = '0;
      plays = '0;
      vol = '0;
      seeks = '0;
    end
    return r;
  endfunction

  function automatic void cmp(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    bprl_pkg::result_t want;
    if (rst) begin
      reset_keys();
      expected_reports.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bprl_pkg::REG_VOLUME_STEP:  cfg.volume_step = cfg_data[6:0];
          bprl_pkg::REG_REPEAT_DELAY: cfg.repeat_initial_delay = cfg_data;
          bprl_pkg::REG_REPEAT_IVAL:  cfg.repeat_interval = cfg_data;
          bprl_pkg::REG_POWER_HOLD:   cfg.power_hold_time = cfg_data;
          bprl_pkg::REG_SEEK_HOLD:    cfg.seek_hold_time = cfg_data;
          bprl_pkg::REG_SEEK_IVAL:    cfg.seek_interval = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("result with no item pending");
          errors++;
        end else begin
          want = expected_reports.pop_front();
          cmp("power_tap", 32'(want.power_tap), 32'(power_tap));
          cmp("power_long", 32'(want.power_long), 32'(power_long));
          cmp("play_count", 32'(want.play_count), 32'(play_count));
          cmp("next_tap", 32'(want.next_tap), 32'(next_tap));
          cmp("prev_tap", 32'(want.prev_tap), 32'(prev_tap));
          cmp("volume_change", 32'(want.volume_change), 32'(volume_change));
          cmp("seek_steps", 32'(want.seek_steps), 32'(seek_steps));
          cmp("seek_first", 32'(want.seek_first), 32'(seek_first));
        end
      end
      if (in_valid && !in_stall) expected_reports.push_back(predict_key_item(action, key));
    end
    outstanding <= expected_reports.size();
  end

endmodule

>>> bench/tb_top.sv
// Testbench top for button_press_repeat_longpress_core: clock, reset, config phases,
// directed and random key items with random idling; verdict from media_key_checker.
// Depends on bprl_pkg, media_key_checker and the core.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         action = bprl_pkg::ACT_TICK;
  logic [2:0]         key = bprl_pkg::KEY_PWR;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               power_tap, power_long, next_tap, prev_tap, seek_first;
  logic [7:0]         play_count;
  logic signed [15:0] volume_change;
  logic [15:0]        seek_steps;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = bprl_pkg::REG_VOLUME_STEP;
  logic [15:0]        cfg_data = '0;

  int fail_count;
  int results_due;
  int gap_max = 15;
  int stall_max = 15;
  int span = 40;
  int item_count = 0;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  button_press_repeat_longpress_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .key(key),
    .out_valid(out_valid), .out_stall(out_stall),
    .power_tap(power_tap), .power_long(power_long), .play_count(play_count),
    .next_tap(next_tap), .prev_tap(prev_tap), .volume_change(volume_change),
    .seek_steps(seek_steps), .seek_first(seek_first),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  media_key_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .key(key),
    .out_valid(out_valid), .out_stall(out_stall),
    .power_tap(power_tap), .power_long(power_long), .play_count(play_count),
    .next_tap(next_tap), .prev_tap(prev_tap), .volume_change(volume_change),
    .seek_steps(seek_steps), .seek_first(seek_first),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(fail_count), .outstanding(results_due)
  );

  task automatic send(input logic [1:0] a, input logic [2:0] k);
    int g;
    g = $urandom_range(0, gap_max);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= a;
    key <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (a == bprl_pkg::ACT_TICK || a == bprl_pkg::ACT_CLEAR || k <= bprl_pkg::KEY_VOLDN)
      item_count++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_cfg(input bprl_pkg::cfg_t c, input bit spare);
    settle();
    put_reg(bprl_pkg::REG_VOLUME_STEP, {9'($urandom), c.volume_step});
    put_reg(bprl_pkg::REG_REPEAT_DELAY, c.repeat_initial_delay);
    put_reg(bprl_pkg::REG_REPEAT_IVAL, c.repeat_interval);
    put_reg(bprl_pkg::REG_POWER_HOLD, c.power_hold_time);
    put_reg(bprl_pkg::REG_SEEK_HOLD, c.seek_hold_time);
    put_reg(bprl_pkg::REG_SEEK_IVAL, c.seek_interval);
    if (spare) begin
      put_reg(REG_SPARE_LO, 16'($urandom));
      put_reg(REG_SPARE_HI, 16'($urandom));
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bprl_pkg::cfg_t make_cfg(input logic [6:0] st, input logic [15:0] dly,
                                              input logic [15:0] ivl, input logic [15:0] pwr,
                                              input logic [15:0] sk, input logic [15:0] ski);
    bprl_pkg::cfg_t c;
    c = {st, dly, ivl, pwr, sk, ski};
    return c;
  endfunction

  function automatic bprl_pkg::cfg_t rand_cfg(input int hi);
    return make_cfg(7'($urandom_range(1, 100)), 16'($urandom_range(1, hi)),
                    16'($urandom_range(1, hi)), 16'($urandom_range(1, hi)),
                    16'($urandom_range(1, hi)), 16'($urandom_range(1, hi)));
  endfunction

  task automatic hold_key(input logic [2:0] k, input int ticks);
    send(bprl_pkg::ACT_DOWN, k);
    repeat (ticks) send(bprl_pkg::ACT_TICK, 3'($urandom));
    send(bprl_pkg::ACT_UP, k);
  endtask

  // mostly press / hold / release with random noise mixed in
  task automatic traffic(input int budget);
    int stop;
    int pick;
    int n;
    logic [2:0] k;
    stop = item_count + budget;
    while (item_count < stop) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        k = 3'($urandom_range(0, 5));
        send(bprl_pkg::ACT_DOWN, k);
        n = $urandom_range(0, 2 * span + 2);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) send(2'($urandom), 3'($urandom));
          else send(bprl_pkg::ACT_TICK, 3'($urandom));
        end
        if ($urandom_range(0, 9) != 0) send(bprl_pkg::ACT_UP, k);
        if ($urandom_range(0, 3) == 0) send(bprl_pkg::ACT_CLEAR, 3'($urandom));
      end else if (pick < 9) begin
        send(2'($urandom), 3'($urandom));
      end else begin
        send(bprl_pkg::ACT_CLEAR, 3'($urandom));
      end
    end
  endtask

  // result side: random stall per item, one long hold-off on request
  initial begin : drain
    int n;
    forever begin
      if (hold_req) begin
        n = 80;
        hold_req = 1'b0;
      end else begin
        n = $urandom_range(0, stall_max);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, directed corners
    send(bprl_pkg::ACT_CLEAR, 3'd7);
    for (int k = 0; k < 8; k++) send(bprl_pkg::ACT_DOWN, 3'(k));
    send(bprl_pkg::ACT_TICK, bprl_pkg::KEY_PLAY);
    for (int k = 0; k < 8; k++) send(bprl_pkg::ACT_UP, 3'(k));
    send(bprl_pkg::ACT_UP, bprl_pkg::KEY_PWR);
    send(bprl_pkg::ACT_DOWN, bprl_pkg::KEY_NEXT);
    send(bprl_pkg::ACT_DOWN, bprl_pkg::KEY_NEXT);
    send(bprl_pkg::ACT_CLEAR, bprl_pkg::KEY_PLAY);
    send(bprl_pkg::ACT_TICK, bprl_pkg::KEY_VOLDN);

    // long hold at reset timing: long press, seek and volume repeat
    gap_max = 2;
    stall_max = 2;
    send(bprl_pkg::ACT_DOWN, bprl_pkg::KEY_PWR);
    send(bprl_pkg::ACT_DOWN, bprl_pkg::KEY_VOLUP);
    repeat (705) send(bprl_pkg::ACT_TICK, 3'($urandom));
    send(bprl_pkg::ACT_UP, bprl_pkg::KEY_PWR);
    send(bprl_pkg::ACT_UP, bprl_pkg::KEY_NEXT);
    send(bprl_pkg::ACT_UP, bprl_pkg::KEY_VOLUP);
    send(bprl_pkg::ACT_CLEAR, bprl_pkg::KEY_PWR);
    gap_max = 15;
    stall_max = 15;
    traffic(80);

    // shortest times, no sender idling, long receiver hold-off
    load_cfg(make_cfg(7'd100, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1), 1'b0);
    gap_max = 0;
    span = 4;
    hold_req = 1'b1;
    traffic(120);

    // all zero, no receiver stalls
    load_cfg(make_cfg(7'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0), 1'b0);
    gap_max = 15;
    stall_max = 0;
    span = 3;
    traffic(100);

    // largest values
    load_cfg(make_cfg(7'd127, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff), 1'b1);
    stall_max = 15;
    span = 20;
    traffic(80);

    // random small settings
    load_cfg(rand_cfg(30), 1'b1);
    gap_max = 6;
    stall_max = 6;
    span = 30;
    traffic(120);

    // saturation of volume and play count
    load_cfg(make_cfg(7'd127, 16'd0, 16'd0, 16'd5, 16'd5, 16'd1), 1'b0);
    gap_max = 0;
    stall_max = 2;
    hold_req = 1'b1;
    hold_key(bprl_pkg::KEY_VOLUP, 265);
    send(bprl_pkg::ACT_CLEAR, bprl_pkg::KEY_VOLUP);
    hold_key(bprl_pkg::KEY_VOLDN, 265);
    send(bprl_pkg::ACT_CLEAR, bprl_pkg::KEY_VOLDN);
    repeat (260) send(bprl_pkg::ACT_DOWN, bprl_pkg::KEY_PLAY);
    send(bprl_pkg::ACT_CLEAR, bprl_pkg::KEY_PLAY);
    hold_key(bprl_pkg::KEY_NEXT, 40);
    hold_key(bprl_pkg::KEY_PWR, 10);
    send(bprl_pkg::ACT_CLEAR, bprl_pkg::KEY_NEXT);

    // random mid settings
    load_cfg(rand_cfg(60), 1'b0);
    gap_max = 15;
    stall_max = 15;
    span = 40;
    traffic(80);

    settle();
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
